### rtl/mvwc_pkg.sv
// ----------------------------------------------------------------------------
// mvwc_pkg
// Shared types, constants and helpers of the motion vector window classifier.
// ----------------------------------------------------------------------------
package mvwc_pkg;

   // Parameter defaults
   localparam int DefMaxPoints = 1024;
   localparam int DefMaxWindow = 64;

   // Field widths
   localparam int CoordW   = 16;
   localparam int CntW     = 7;
   localparam int MinPtsW  = 11;
   localparam int EnergyW  = 25;
   localparam int PtEnergyW = 15;   // a moving point's d2 is below 25600
   localparam int SqW      = 2 * CoordW;
   localparam int D2W      = SqW + 1;

   // Fixed point thresholds of d2 (8 fraction bits)
   localparam int OneFx     = 256;
   localparam int HundredFx = 25600;
   localparam int FracShift = 8;

   localparam int CntMax = 127;

   // Division of a 7-bit value by three as multiply and shift
   localparam int DivThreeMul   = 43;
   localparam int DivThreeShift = 7;

   // Configuration port
   localparam int CsrAddrW = 3;
   localparam int CsrDataW = 32;
   localparam logic [CntW-1:0]    WindowReset = 7'd15;
   localparam logic [MinPtsW-1:0] MinPtsReset = 11'd12;

   typedef enum logic [0:0] {
      RegWindowFrames = 1'b0,
      RegMinPoints    = 1'b1
   } reg_idx_type;

   typedef struct packed {
      logic [CntW-1:0]    window_frames;
      logic [MinPtsW-1:0] min_points;
   } cfg_type;

   // Classified point handed from the point pipeline to the accumulator
   typedef struct packed {
      logic                 valid;
      logic                 point_valid;
      logic                 frame_end;
      logic                 is_static;
      logic                 is_moving;
      logic [PtEnergyW-1:0] energy;
      logic [1:0]           bin;
   } point_type;

   function automatic logic [CntW-1:0] div3(input logic [CntW-1:0] v);
      logic [CntW+5:0] p;
      p = (CntW+6)'(v) * (CntW+6)'(DivThreeMul);
      return CntW'(p >> DivThreeShift);
   endfunction

endpackage

### rtl/mvwc_if.sv
// ----------------------------------------------------------------------------
// mvwc_req_if / mvwc_rsp_if
// Valid/ready channels for tracked points and window verdicts.
// ----------------------------------------------------------------------------
interface mvwc_req_if;
   import mvwc_pkg::*;
   logic              valid;
   logic              ready;
   logic [CoordW-1:0] prev_x;
   logic [CoordW-1:0] prev_y;
   logic [CoordW-1:0] curr_x;
   logic [CoordW-1:0] curr_y;
   logic              point_valid;
   logic              frame_end;

   modport source (output valid, prev_x, prev_y, curr_x, curr_y, point_valid, frame_end,
                   input ready);
   modport sink (input valid, prev_x, prev_y, curr_x, curr_y, point_valid, frame_end,
                 output ready);
endinterface

interface mvwc_rsp_if;
   import mvwc_pkg::*;
   logic            valid;
   logic            ready;
   logic            fire_like;
   logic            points_ok;
   logic            energy_ok;
   logic [CntW-1:0] pass_frames;
   logic [CntW-1:0] static_frames;
   logic [CntW-1:0] empty_dir_frames;
   logic [CntW-1:0] sparse_frames;

   modport source (output valid, fire_like, points_ok, energy_ok, pass_frames,
                   static_frames, empty_dir_frames, sparse_frames, input ready);
   modport sink (input valid, fire_like, points_ok, energy_ok, pass_frames,
                 static_frames, empty_dir_frames, sparse_frames, output ready);
endinterface

### rtl/motion_vector_window_classifier.sv
// ----------------------------------------------------------------------------
// motion_vector_window_classifier
// Classifies tracked point motion per frame and issues a verdict per window.
// ----------------------------------------------------------------------------
// Path: a closing transfer passes the squares and classification stages, then sets the verdict register.
// Throughput: one point per cycle unless the input stalls.
// The input stalls only when a verdict is due while the previous one waits.
// Reset clears all frame and window state; registers return to 15 and 12.
// ----------------------------------------------------------------------------
module motion_vector_window_classifier #(
   parameter int MAX_POINTS = mvwc_pkg::DefMaxPoints,
   parameter int MAX_WINDOW = mvwc_pkg::DefMaxWindow
) (
   input  logic                          clock,
   input  logic                          reset,
   mvwc_req_if.sink                      req_ch,
   mvwc_rsp_if.source                    rsp_ch,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [mvwc_pkg::CsrAddrW-1:0] paddr,
   input  logic [mvwc_pkg::CsrDataW-1:0] pwdata,
   output logic [mvwc_pkg::CsrDataW-1:0] prdata,
   output logic                          pready
);
   import mvwc_pkg::*;

   cfg_type   cfg;
   point_type pt;
   logic      take;

   mvwc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   mvwc_point u_point (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .take  (take),
      .pt    (pt)
   );

   mvwc_accum #(
      .MAX_POINTS (MAX_POINTS),
      .MAX_WINDOW (MAX_WINDOW)
   ) u_accum (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .pt    (pt),
      .take  (take),
      .rsp   (rsp_ch)
   );

   a_reset_no_verdict: assert property (@(posedge clock)
      $past(reset) |-> !rsp_ch.valid)
      else $error("verdict valid right after reset");

   a_fire_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.fire_like == (rsp_ch.points_ok && rsp_ch.energy_ok)))
      else $error("fire_like disagrees with its component tests");

   a_energy_needs_pass: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.energy_ok) |-> (rsp_ch.pass_frames != '0))
      else $error("energy test passed with no passing frames");

   a_stall_only_on_verdict: assert property (@(posedge clock) disable iff (reset)
      (!req_ch.ready && !$past(reset)) |-> (rsp_ch.valid && !rsp_ch.ready))
      else $error("input stalled without a waiting verdict");

endmodule

### rtl/mvwc_csr.sv
// ----------------------------------------------------------------------------
// mvwc_csr
// APB-style register file: window length and sparse-frame threshold.
// ----------------------------------------------------------------------------
module mvwc_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [mvwc_pkg::CsrAddrW-1:0] paddr,
   input  logic [mvwc_pkg::CsrDataW-1:0] pwdata,
   output logic [mvwc_pkg::CsrDataW-1:0] prdata,
   output logic                          pready,
   output mvwc_pkg::cfg_type             cfg
);
   import mvwc_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   reg_idx_type idx;
   logic        wr_en;

   assign idx    = reg_idx_type'(paddr[2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            RegWindowFrames: cfg_in.window_frames = pwdata[CntW-1:0];
            RegMinPoints:    cfg_in.min_points    = pwdata[MinPtsW-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         RegWindowFrames: prdata = CsrDataW'(cfg_ff.window_frames);
         RegMinPoints:    prdata = CsrDataW'(cfg_ff.min_points);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_frames <= WindowReset;
         cfg_ff.min_points    <= MinPtsReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/mvwc_point.sv
// ----------------------------------------------------------------------------
// mvwc_point
// Two-stage point pipeline: squared axis displacements and direction bin, then
// d2 classification.
// ----------------------------------------------------------------------------
module mvwc_point (
   input  logic                clock,
   input  logic                reset,
   mvwc_req_if.sink            req,
   input  logic                take,
   output mvwc_pkg::point_type pt
);
   import mvwc_pkg::*;

   // stage 1: squares
   logic              s1_vld_ff, s1_vld_in;
   logic [SqW-1:0]    s1_sqx_ff, s1_sqy_ff;
   logic              s1_pv_ff, s1_fe_ff;
   logic [1:0]        s1_bin_ff;
   // stage 2: classified point
   logic              s2_vld_ff, s2_vld_in;
   point_type         s2_ff, s2_in;

   logic              adv1, adv2;
   logic [CoordW-1:0] dx, dy;
   logic [D2W-1:0]    d2;

   assign adv2      = !s2_vld_ff || take;
   assign adv1      = !s1_vld_ff || adv2;
   assign req.ready = adv1;

   assign dx = (req.prev_x >= req.curr_x) ? req.prev_x - req.curr_x : req.curr_x - req.prev_x;
   assign dy = (req.prev_y >= req.curr_y) ? req.prev_y - req.curr_y : req.curr_y - req.prev_y;

   assign s1_vld_in = adv1 ? req.valid : s1_vld_ff;
   assign s2_vld_in = adv2 ? s1_vld_ff : s2_vld_ff;

   assign d2 = D2W'(s1_sqx_ff) + D2W'(s1_sqy_ff);

   always_comb begin
      s2_in             = s2_ff;
      s2_in.valid       = 1'b1;
      s2_in.point_valid = s1_pv_ff;
      s2_in.frame_end   = s1_fe_ff;
      s2_in.is_static   = d2 < D2W'(OneFx);
      s2_in.is_moving   = (d2 >= D2W'(OneFx)) && (d2 < D2W'(HundredFx));
      s2_in.energy      = d2[PtEnergyW-1:0];
      s2_in.bin         = s1_bin_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s2_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1 && req.valid) begin
         s1_sqx_ff <= SqW'(dx) * SqW'(dx);
         s1_sqy_ff <= SqW'(dy) * SqW'(dy);
         s1_pv_ff  <= req.point_valid;
         s1_fe_ff  <= req.frame_end;
         s1_bin_ff <= {req.prev_y < req.curr_y, req.prev_x < req.curr_x};
      end
      if (adv2 && s1_vld_ff) begin
         s2_ff <= s2_in;
      end
   end

   always_comb begin
      pt       = s2_ff;
      pt.valid = s2_vld_ff;
   end

endmodule

### rtl/mvwc_accum.sv
// ----------------------------------------------------------------------------
// mvwc_accum
// Frame accumulators, per-window frame counters and the verdict register.
// ----------------------------------------------------------------------------
module mvwc_accum #(
   parameter int MAX_POINTS = mvwc_pkg::DefMaxPoints,
   parameter int MAX_WINDOW = mvwc_pkg::DefMaxWindow
) (
   input  logic                clock,
   input  logic                reset,
   input  mvwc_pkg::cfg_type   cfg,
   input  mvwc_pkg::point_type pt,
   output logic                take,
   mvwc_rsp_if.source          rsp
);
   import mvwc_pkg::*;

   localparam int PtsW   = $clog2(MAX_POINTS + 1);
   localparam int MinW   = (PtsW > MinPtsW) ? PtsW : MinPtsW;
   localparam int CmpW   = (EnergyW > PtsW + 7) ? EnergyW : PtsW + 7;
   localparam int WinCap = (MAX_WINDOW < CntMax) ? MAX_WINDOW : CntMax;

   logic [EnergyW-1:0] energy_ff, energy_in;
   logic [PtsW-1:0]    stat_ff, stat_in, mov_ff, mov_in, pts_ff, pts_in;
   logic [3:0]         dir_ff, dir_in;
   logic [CntW-1:0]    cnt_ff [4];
   logic [CntW-1:0]    cnt_in [4];
   logic [CntW-1:0]    done_ff, done_in;
   logic               out_vld_ff, out_vld_in;
   logic               fire_ff, pts_ok_ff, en_ok_ff;
   logic [CntW-1:0]    verdict_cnt_ff [4];

   logic               add, mov_add, fin, out_busy, step;
   logic [PtsW-1:0]    pts_new, stat_new, mov_new;
   logic [EnergyW:0]   esum;
   logic [EnergyW-1:0] energy_new;
   logic [3:0]         dir_new, hit;
   logic [CmpW-1:0]    half_moving;
   logic [CntW-1:0]    cnt_bump [4];
   logic [CntW-1:0]    done_inc, w;
   logic               pts_ok, en_ok;

   // per-point accumulation
   assign add      = pt.valid && pt.point_valid && (pts_ff < PtsW'(MAX_POINTS));
   assign mov_add  = add && pt.is_moving;
   assign pts_new  = pts_ff + PtsW'(add);
   assign stat_new = stat_ff + PtsW'(add && pt.is_static);
   assign mov_new  = mov_ff + PtsW'(mov_add);
   assign esum     = {1'b0, energy_ff} + (mov_add ? (EnergyW+1)'(pt.energy) : '0);
   assign energy_new = esum[EnergyW] ? {EnergyW{1'b1}} : esum[EnergyW-1:0];
   assign dir_new  = dir_ff | (add ? (4'b0001 << pt.bin) : 4'b0000);

   // frame close tests
   assign half_moving = CmpW'(mov_new >> 1) << FracShift;
   assign hit[0] = CmpW'(energy_new) > half_moving;
   assign hit[1] = stat_new > (pts_new >> 1);
   assign hit[2] = dir_new != 4'hF;
   assign hit[3] = MinW'(pts_new) < MinW'(cfg.min_points);

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         cnt_bump[i] = cnt_ff[i] + CntW'(hit[i] && (cnt_ff[i] != CntW'(CntMax)));
      end
   end

   assign done_inc = done_ff + CntW'(done_ff != CntW'(CntMax));

   // effective window length, clamped
   always_comb begin
      priority if (cfg.window_frames == '0) begin
         w = CntW'(1);
      end else if (cfg.window_frames > CntW'(WinCap)) begin
         w = CntW'(WinCap);
      end else begin
         w = cfg.window_frames;
      end
   end

   assign fin      = pt.valid && pt.frame_end && (done_inc >= w);
   assign out_busy = out_vld_ff && !rsp.ready;
   assign take     = !(fin && out_busy);
   assign step     = pt.valid && take;

   assign pts_ok = cnt_bump[3] < div3(w);
   assign en_ok  = (cnt_bump[0] > (w >> 1)) && (cnt_bump[1] < (w >> 2)) &&
                   (cnt_bump[2] < (w >> 3) + CntW'(1));

   always_comb begin
      energy_in = energy_ff;
      stat_in   = stat_ff;
      mov_in    = mov_ff;
      pts_in    = pts_ff;
      dir_in    = dir_ff;
      cnt_in    = cnt_ff;
      done_in   = done_ff;
      if (step) begin
         if (pt.frame_end) begin
            energy_in = '0;
            stat_in   = '0;
            mov_in    = '0;
            pts_in    = '0;
            dir_in    = '0;
            if (fin) begin
               for (int i = 0; i < 4; i++) cnt_in[i] = '0;
               done_in = '0;
            end else begin
               cnt_in  = cnt_bump;
               done_in = done_inc;
            end
         end else begin
            energy_in = energy_new;
            stat_in   = stat_new;
            mov_in    = mov_new;
            pts_in    = pts_new;
            dir_in    = dir_new;
         end
      end
   end

   // hold a verdict until the sink takes it
   always_comb begin
      priority if (step && fin) begin
         out_vld_in = 1'b1;
      end else if (rsp.ready) begin
         out_vld_in = 1'b0;
      end else begin
         out_vld_in = out_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         energy_ff  <= '0;
         stat_ff    <= '0;
         mov_ff     <= '0;
         pts_ff     <= '0;
         dir_ff     <= '0;
         for (int i = 0; i < 4; i++) cnt_ff[i] <= '0;
         done_ff    <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         energy_ff  <= energy_in;
         stat_ff    <= stat_in;
         mov_ff     <= mov_in;
         pts_ff     <= pts_in;
         dir_ff     <= dir_in;
         cnt_ff     <= cnt_in;
         done_ff    <= done_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && fin) begin
         fire_ff        <= pts_ok && en_ok;
         pts_ok_ff      <= pts_ok;
         en_ok_ff       <= en_ok;
         verdict_cnt_ff <= cnt_bump;
      end
   end

   assign rsp.valid            = out_vld_ff;
   assign rsp.fire_like        = fire_ff;
   assign rsp.points_ok        = pts_ok_ff;
   assign rsp.energy_ok        = en_ok_ff;
   assign rsp.pass_frames      = verdict_cnt_ff[0];
   assign rsp.static_frames    = verdict_cnt_ff[1];
   assign rsp.empty_dir_frames = verdict_cnt_ff[2];
   assign rsp.sparse_frames    = verdict_cnt_ff[3];

endmodule

### verif/motion_vector_window_classifier_test.sv
// ----------------------------------------------------------------------------
// motion_vector_window_classifier_test
// Drives tracked points through the classifier frame by frame under several
// window and sparse-frame settings, predicts every window verdict and checks
// each one field by field as it leaves the block.
// ----------------------------------------------------------------------------
module motion_vector_window_classifier_test;
   timeunit 1ns;
   timeprecision 1ps;

   import mvwc_pkg::*;

   localparam int CycleLimit    = 400000;
   localparam int DrainCycles   = 8;
   localparam int ItemTarget    = 500;
   localparam int VerdictTarget = 40;
   localparam int NumPlanned    = 9;
   localparam int PlanWindow [NumPlanned] = '{1, 2, 3, 0, 4, 127, 64, 6, 2};
   localparam int PlanMinPts [NumPlanned] = '{0, 1, 2047, 5, 3, 4, 0, 8, 1024};
   localparam int EnergyMax = (1 << EnergyW) - 1;

   typedef struct packed {
      logic [CoordW-1:0] prev_x;
      logic [CoordW-1:0] prev_y;
      logic [CoordW-1:0] curr_x;
      logic [CoordW-1:0] curr_y;
      logic              point_valid;
      logic              frame_end;
   } tracked_point_type;

   typedef struct packed {
      logic            fire_like;
      logic            points_ok;
      logic            energy_ok;
      logic [CntW-1:0] pass_frames;
      logic [CntW-1:0] static_frames;
      logic [CntW-1:0] empty_dir_frames;
      logic [CntW-1:0] sparse_frames;
   } window_verdict_type;

   class window_verdict_model;
      logic [CntW-1:0]    window_frames = WindowReset;
      logic [MinPtsW-1:0] min_points    = MinPtsReset;

      logic [EnergyW-1:0] energy_sum;
      logic [MinPtsW-1:0] static_points;
      logic [MinPtsW-1:0] moving_points;
      logic [MinPtsW-1:0] frame_points;
      logic [3:0]         dir_seen;
      logic [CntW-1:0]    pass_frames;
      logic [CntW-1:0]    static_frames;
      logic [CntW-1:0]    empty_dir_frames;
      logic [CntW-1:0]    sparse_frames;
      logic [CntW-1:0]    frames_done;

      window_verdict_type pending_verdicts[$];
      int unsigned        mismatches;
      int unsigned        verdicts_seen;

      function new();
         clear_frame();
         clear_window();
         mismatches    = 0;
         verdicts_seen = 0;
      endfunction

      function void clear_frame();
         energy_sum    = '0;
         static_points = '0;
         moving_points = '0;
         frame_points  = '0;
         dir_seen      = '0;
      endfunction

      function void clear_window();
         pass_frames      = '0;
         static_frames    = '0;
         empty_dir_frames = '0;
         sparse_frames    = '0;
         frames_done      = '0;
      endfunction

      function logic [CntW-1:0] bump(logic [CntW-1:0] c);
         return (c < CntMax) ? c + 1'b1 : c;
      endfunction

      function int pending();
         return pending_verdicts.size();
      endfunction

      // Advance the frame and window state by one accepted transfer.
      function void take_point(tracked_point_type it);
         logic [CoordW-1:0]  dx;
         logic [CoordW-1:0]  dy;
         logic [D2W-1:0]     d2;
         logic [EnergyW:0]   sum;
         int                 w;
         window_verdict_type v;
         if (it.point_valid && frame_points < MinPtsW'(DefMaxPoints)) begin
            frame_points++;
            dx = (it.prev_x >= it.curr_x) ? it.prev_x - it.curr_x : it.curr_x - it.prev_x;
            dy = (it.prev_y >= it.curr_y) ? it.prev_y - it.curr_y : it.curr_y - it.prev_y;
            d2 = D2W'(dx) * D2W'(dx) + D2W'(dy) * D2W'(dy);
            if (d2 < OneFx) begin
               static_points++;
            end else if (d2 < HundredFx) begin
               moving_points++;
               sum = (EnergyW+1)'(energy_sum) + (EnergyW+1)'(d2);
               energy_sum = (sum > EnergyMax) ? EnergyW'(EnergyMax) : EnergyW'(sum);
            end
            dir_seen[{it.prev_y < it.curr_y, it.prev_x < it.curr_x}] = 1'b1;
         end
         if (!it.frame_end) return;

         if (int'(energy_sum) > int'(moving_points >> 1) * OneFx)
            pass_frames = bump(pass_frames);
         if (static_points > (frame_points >> 1))
            static_frames = bump(static_frames);
         if (dir_seen != 4'hF)
            empty_dir_frames = bump(empty_dir_frames);
         if (frame_points < min_points)
            sparse_frames = bump(sparse_frames);
         clear_frame();
         frames_done = bump(frames_done);

         w = int'(window_frames);
         if (w < 1) w = 1;
         if (w > DefMaxWindow) w = DefMaxWindow;
         if (int'(frames_done) < w) return;

         v.points_ok        = int'(sparse_frames) < w / 3;
         v.energy_ok        = int'(pass_frames) > (w >> 1) &&
                              int'(static_frames) < (w >> 2) &&
                              int'(empty_dir_frames) < (w >> 3) + 1;
         v.fire_like        = v.points_ok & v.energy_ok;
         v.pass_frames      = pass_frames;
         v.static_frames    = static_frames;
         v.empty_dir_frames = empty_dir_frames;
         v.sparse_frames    = sparse_frames;
         pending_verdicts = {pending_verdicts, v};
         clear_window();
      endfunction

      function void check_field(string name, int exp_val, int act_val);
         if (exp_val != act_val) begin
            $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
            mismatches++;
         end
      endfunction

      function void match_verdict(window_verdict_type got);
         window_verdict_type exp_v;
         verdicts_seen++;
         if (pending_verdicts.size() == 0) begin
            $error("verdict with none pending: %p", got);
            mismatches++;
            return;
         end
         exp_v = pending_verdicts.pop_front();
         check_field("fire_like", exp_v.fire_like, got.fire_like);
         check_field("points_ok", exp_v.points_ok, got.points_ok);
         check_field("energy_ok", exp_v.energy_ok, got.energy_ok);
         check_field("pass_frames", exp_v.pass_frames, got.pass_frames);
         check_field("static_frames", exp_v.static_frames, got.static_frames);
         check_field("empty_dir_frames", exp_v.empty_dir_frames, got.empty_dir_frames);
         check_field("sparse_frames", exp_v.sparse_frames, got.sparse_frames);
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [CsrAddrW-1:0] paddr;
   logic [CsrDataW-1:0] pwdata;
   logic [CsrDataW-1:0] prdata;
   logic                pready;

   mvwc_req_if req_ch ();
   mvwc_rsp_if rsp_ch ();

   window_verdict_model model;
   int unsigned         src_idle_pct;
   int unsigned         snk_idle_pct;
   int unsigned         rsp_hold_cycles;
   int unsigned         points_sent;
   int unsigned         cycles;

   motion_vector_window_classifier u_top (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      cycles = 0;
      while (cycles < CycleLimit) begin
         @(posedge clock);
         cycles++;
      end
      $display("FAIL");
      $finish;
   end

   // Result side: check each transfer, then pick ready for the next edge.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready)
            model.match_verdict('{rsp_ch.fire_like, rsp_ch.points_ok, rsp_ch.energy_ok,
                                  rsp_ch.pass_frames, rsp_ch.static_frames,
                                  rsp_ch.empty_dir_frames, rsp_ch.sparse_frames});
         if (rsp_hold_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_hold_cycles--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
         end
      end
   end

   task automatic csr_access(input logic wr, input reg_idx_type idx,
                             input logic [CsrDataW-1:0] wdata,
                             output logic [CsrDataW-1:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= CsrAddrW'(4 * int'(idx));
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_config(input int unsigned window_val, input int unsigned min_val);
      logic [CsrDataW-1:0] rd;
      csr_access(1'b1, RegWindowFrames, CsrDataW'(window_val), rd);
      model.window_frames = CntW'(window_val);
      csr_access(1'b1, RegMinPoints, CsrDataW'(min_val), rd);
      model.min_points = MinPtsW'(min_val);
      csr_access(1'b0, RegWindowFrames, '0, rd);
      if (rd != CsrDataW'(model.window_frames)) begin
         $error("window_frames readback: expected %0d, actual %0d", model.window_frames, rd);
         model.mismatches++;
      end
      csr_access(1'b0, RegMinPoints, '0, rd);
      if (rd != CsrDataW'(model.min_points)) begin
         $error("min_points readback: expected %0d, actual %0d", model.min_points, rd);
         model.mismatches++;
      end
   endtask

   // Offer one transfer and note it in the model once it is taken.
   task automatic send_item(input tracked_point_type it);
      while ($urandom_range(99) < src_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.prev_x      <= it.prev_x;
      req_ch.prev_y      <= it.prev_y;
      req_ch.curr_x      <= it.curr_x;
      req_ch.curr_y      <= it.curr_y;
      req_ch.point_valid <= it.point_valid;
      req_ch.frame_end   <= it.frame_end;
      do @(posedge clock); while (!req_ch.ready);
      model.take_point(it);
   endtask

   task automatic send_fields(input int unsigned px, input int unsigned py,
                              input int unsigned cx, input int unsigned cy,
                              input logic pv, input logic fe);
      send_item('{CoordW'(px), CoordW'(py), CoordW'(cx), CoordW'(cy), pv, fe});
      points_sent++;
   endtask

   // Place a displacement of mag on one axis, in a random direction.
   function automatic void place_axis(input int unsigned mag,
                                      output logic [CoordW-1:0] p,
                                      output logic [CoordW-1:0] c);
      if ($urandom_range(1)) begin
         p = CoordW'($urandom_range(65535 - mag));
         c = p + CoordW'(mag);
      end else begin
         p = CoordW'($urandom_range(65535, mag));
         c = p - CoordW'(mag);
      end
   endfunction

   function automatic tracked_point_type noise_item();
      tracked_point_type it;
      it.prev_x      = CoordW'($urandom);
      it.prev_y      = CoordW'($urandom);
      it.curr_x      = CoordW'($urandom);
      it.curr_y      = CoordW'($urandom);
      it.point_valid = 1'b0;
      it.frame_end   = 1'b0;
      return it;
   endfunction

   function automatic tracked_point_type random_point();
      tracked_point_type it;
      int unsigned       mx;
      int unsigned       my;
      int unsigned       r;
      int unsigned       pick;
      r = $urandom_range(99);
      if (r < 20) begin
         mx = $urandom_range(11);
         my = $urandom_range(11);
      end else if (r < 25) begin
         // thresholds of d2: just under and at 1.0 and 100.0
         pick = $urandom_range(3);
         mx = (pick == 0) ? 16 : (pick == 1) ? 15 : (pick == 2) ? 160 : 159;
         my = (pick == 0) ? 0 : (pick == 1) ? 5 : (pick == 2) ? 0 : 17;
         if ($urandom_range(1)) begin
            my = mx + my;
            mx = my - mx;
            my = my - mx;
         end
      end else if (r < 70) begin
         mx = $urandom_range(113);
         my = $urandom_range(113);
      end else begin
         mx = $urandom_range(65535);
         my = $urandom_range(65535);
      end
      if (r >= 85) begin
         it = noise_item();
      end else begin
         place_axis(mx, it.prev_x, it.curr_x);
         place_axis(my, it.prev_y, it.curr_y);
      end
      it.point_valid = 1'b1;
      it.frame_end   = 1'b0;
      return it;
   endfunction

   task automatic send_frame(input int unsigned n_points);
      tracked_point_type it;
      logic              close_on_point;
      int unsigned       i;
      close_on_point = (n_points > 0) && ($urandom_range(99) < 70);
      for (i = 0; i < n_points; i++) begin
         if ($urandom_range(99) < 6)
            send_item(noise_item());
         it = random_point();
         it.frame_end = close_on_point && (i == n_points - 1);
         send_item(it);
         points_sent++;
      end
      if (!close_on_point) begin
         it = noise_item();
         it.frame_end = 1'b1;
         send_item(it);
         points_sent++;
      end
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (model.pending() != 0) @(posedge clock);
   endtask

   task automatic run_directed();
      tracked_point_type it;
      send_fields(0, 0, 0, 0, 1'b1, 1'b0);
      send_fields(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
      send_fields(0, 0, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
      send_fields(16'hFFFF, 16'hFFFF, 0, 0, 1'b1, 1'b0);
      send_fields(0, 100, 100, 100, 1'b1, 1'b0);
      send_fields(100, 0, 100, 100, 1'b1, 1'b0);
      send_fields(16, 0, 0, 0, 1'b1, 1'b0);
      send_fields(0, 0, 15, 5, 1'b1, 1'b0);
      send_fields(0, 160, 0, 0, 1'b1, 1'b0);
      send_fields(159, 0, 0, 17, 1'b1, 1'b1);
      // empty frames closed by a transfer that carries no point
      send_fields(16'hFFFF, 0, 0, 16'hFFFF, 1'b0, 1'b1);
      send_fields(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 1'b0, 1'b0);
      send_fields(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 1'b0, 1'b1);
      repeat (12) begin
         it = random_point();
         it.frame_end = 1'b1;
         send_item(it);
         points_sent++;
      end
   endtask

   initial begin
      int unsigned phase;
      int unsigned win_val;
      int unsigned min_val;
      int unsigned w_eff;
      int unsigned n_frames;
      int unsigned f;
      model = new();
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.prev_x      <= '0;
      req_ch.prev_y      <= '0;
      req_ch.curr_x      <= '0;
      req_ch.curr_y      <= '0;
      req_ch.point_valid <= 1'b0;
      req_ch.frame_end   <= 1'b0;
      psel               <= 1'b0;
      penable            <= 1'b0;
      pwrite             <= 1'b0;
      paddr              <= '0;
      pwdata             <= '0;
      src_idle_pct    = 11;
      snk_idle_pct    = 45;
      rsp_hold_cycles = 0;
      points_sent     = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset register values first
      run_directed();
      wait_drained();
      repeat (DrainCycles) @(posedge clock);

      for (phase = 0; phase < NumPlanned || points_sent < ItemTarget ||
                      model.verdicts_seen < VerdictTarget; phase++) begin
         if (phase < 3) begin
            src_idle_pct = 11;
            snk_idle_pct = 45;
         end else if (phase < 6) begin
            src_idle_pct = 45;
            snk_idle_pct = 11;
         end else begin
            src_idle_pct = 0;
            snk_idle_pct = 0;
         end
         if (phase < NumPlanned) begin
            win_val = PlanWindow[phase];
            min_val = PlanMinPts[phase];
         end else begin
            win_val = $urandom_range(1, 8);
            min_val = $urandom_range(12);
         end
         write_config(win_val, min_val);
         w_eff    = (win_val < 1) ? 1 : (win_val > DefMaxWindow) ? DefMaxWindow : win_val;
         n_frames = (w_eff <= 8) ? 12 : w_eff + 2;

         // hold off the result side so the block backs up into its input
         if (phase == 0)
            rsp_hold_cycles = 120;

         for (f = 0; f < n_frames; f++) begin
            if (phase == 4 && f == n_frames / 2)
               wait_drained();
            if (w_eff <= 8)
               send_frame($urandom_range(8));
            else
               send_frame($urandom_range(2));
         end
         wait_drained();
         repeat (DrainCycles) @(posedge clock);
      end

      if (model.mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
